@@ rtl/siphash24_nonce_hash_macros.svh @@
// Assertion macros used by the SipHash RTL.
`ifndef SIPHASH24_NONCE_HASH_MACROS_SVH
`define SIPHASH24_NONCE_HASH_MACROS_SVH

// Same-cycle implication, off during reset.
`define SIP_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define SIP_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sip24_pkg.sv @@
// Types, constants and round functions for the SipHash-2-4 nonce hasher.
package sip24_pkg;

  localparam int NUM_KEYS     = 4;
  localparam int CFG_INDEX_W  = 8;
  localparam int NONCE_W      = 32;
  localparam int HASH_W       = 32;
  // Two compression rounds and four finalization rounds, one half round per stage.
  localparam int NUM_HALVES   = 12;
  // Stage after which the nonce and the finalization constant are folded in.
  localparam int INJECT_STAGE = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0 = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_1 = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_2 = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_3 = 8'd3;

  localparam logic [63:0] FINAL_XOR = 64'h0000_0000_0000_00ff;

  typedef struct packed {
    logic [63:0]        v0;
    logic [63:0]        v1;
    logic [63:0]        v2;
    logic [63:0]        v3;
    logic [NONCE_W-1:0] nonce;
  } sip_state_t;

  // Front half of a SipRound: one level of 64-bit adds.
  function automatic sip_state_t sip_half_a(input sip_state_t s);
    sip_state_t r;
    logic [63:0] a0;
    logic [63:0] a2;
    a0      = s.v0 + s.v1;
    a2      = s.v2 + s.v3;
    r.nonce = s.nonce;
    r.v1    = {s.v1[50:0], s.v1[63:51]} ^ a0;
    r.v3    = {s.v3[47:0], s.v3[63:48]} ^ a2;
    r.v0    = {a0[31:0], a0[63:32]};
    r.v2    = a2;
    return r;
  endfunction

  // Back half of a SipRound.
  function automatic sip_state_t sip_half_b(input sip_state_t s);
    sip_state_t r;
    logic [63:0] a0;
    logic [63:0] a2;
    a2      = s.v2 + s.v1;
    a0      = s.v0 + s.v3;
    r.nonce = s.nonce;
    r.v1    = {s.v1[46:0], s.v1[63:47]} ^ a2;
    r.v3    = {s.v3[42:0], s.v3[63:43]} ^ a0;
    r.v2    = {a2[31:0], a2[63:32]};
    r.v0    = a0;
    return r;
  endfunction

endpackage

@@ rtl/siphash24_nonce_hash.sv @@
// Pipelined SipHash-2-4 over a 32-bit nonce with a configurable key state.
// Stages: the input transfer loads the entry stage, then the twelve half-round
//   stages and the output register follow in order.
// Throughput: one nonce per cycle without output backpressure; each stage moves
//   when the stage after it is empty or moving, so bubbles close up when the output stalls.
// Reset: clears all stage valid bits and the four key words to zero.
`include "siphash24_nonce_hash_macros.svh"

module siphash24_nonce_hash (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sip24_pkg::NONCE_W-1:0]       s_tdata,    // [31:0] nonce
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sip24_pkg::HASH_W-1:0]        m_tdata,    // [31:0] hash_low
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sip24_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [63:0]                         cfg_data
);

  localparam int LAST = sip24_pkg::NUM_HALVES;

  logic [63:0]          key_word [sip24_pkg::NUM_KEYS];
  sip24_pkg::sip_state_t st      [LAST+1];
  sip24_pkg::sip_state_t st_next [LAST+1];
  logic                 vld      [LAST+1];
  logic                 go       [LAST+2];
  logic                 out_vld;
  logic [sip24_pkg::HASH_W-1:0] hash_low;
  logic [63:0]          fold;

  assign cfg_ready = 1'b1;

  // Key registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < sip24_pkg::NUM_KEYS; k++) key_word[k] <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sip24_pkg::REG_KEY_WORD_0: key_word[0] <= cfg_data;
        sip24_pkg::REG_KEY_WORD_1: key_word[1] <= cfg_data;
        sip24_pkg::REG_KEY_WORD_2: key_word[2] <= cfg_data;
        sip24_pkg::REG_KEY_WORD_3: key_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-stage advance: a stage takes new data when empty or when it moves on.
  always_comb begin
    go[LAST+1] = !out_vld || m_tready;
    for (int i = LAST; i >= 0; i--) go[i] = !vld[i] || go[i+1];
  end

  assign s_tready = go[0];

  always_comb begin
    st_next[0].nonce = s_tdata;
    st_next[0].v0    = key_word[0];
    st_next[0].v1    = key_word[1];
    st_next[0].v2    = key_word[2];
    st_next[0].v3    = key_word[3] ^ {32'd0, s_tdata};
    for (int i = 1; i <= LAST; i++) begin
      if (((i - 1) % 2) == 0) st_next[i] = sip24_pkg::sip_half_a(st[i-1]);
      else                    st_next[i] = sip24_pkg::sip_half_b(st[i-1]);
      if (i == sip24_pkg::INJECT_STAGE) begin
        st_next[i].v0 = st_next[i].v0 ^ {32'd0, st_next[i].nonce};
        st_next[i].v2 = st_next[i].v2 ^ sip24_pkg::FINAL_XOR;
      end
    end
    fold = st[LAST].v0 ^ st[LAST].v1 ^ st[LAST].v2 ^ st[LAST].v3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LAST; i++) vld[i] <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (go[0]) vld[0] <= s_tvalid;
      for (int i = 1; i <= LAST; i++) begin
        if (go[i]) vld[i] <= vld[i-1];
      end
      if (go[LAST+1]) out_vld <= vld[LAST];
    end
  end

  // Payload carries no reset; it moves with its stage's valid bit.
  always_ff @(posedge clk) begin
    for (int i = 0; i <= LAST; i++) begin
      if (go[i]) st[i] <= st_next[i];
    end
    if (go[LAST+1]) hash_low <= fold[sip24_pkg::HASH_W-1:0];
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = hash_low;

  `SIP_ASSERT_NEXT(a_accept_fills_entry, clk, rst, s_tvalid && s_tready, vld[0], "accepted nonce lost at entry stage")
  `SIP_ASSERT_NOW(a_stall_from_output, clk, rst, !s_tready, m_tvalid && !m_tready, "input stalled without output backpressure")
  `SIP_ASSERT_NEXT(a_last_stage_drains, clk, rst, vld[LAST] && go[LAST+1], m_tvalid, "final stage did not reach output register")
  `SIP_ASSERT_NOW(a_stall_holds_full, clk, rst, !go[1], vld[1] && out_vld, "mid-pipe stall with empty stages")

endmodule
